// ===== rtl/imm_pkg.sv =====
`default_nettype none

package imm_pkg;

   // field widths fixed by the item formats
   localparam int FUNC_W      = 2;
   localparam int IDX_W       = 3;
   localparam int DATA_W      = 32;
   localparam int DIM_W       = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int MAX_DIM_DEF = 8;

   // item function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE_A = 2'd0,
      FUNC_WRITE_B = 2'd1,
      FUNC_COMPUTE = 2'd2
   } func_type;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROWS_A    = 2'd0,
      CSR_INNER_DIM = 2'd1,
      CSR_COLS_B    = 2'd2
   } csr_index_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_FLUSH,
      ST_EMIT
   } state_type;

   // last usable index for a dimension: zero acts as one, large values saturate
   function automatic logic [IDX_W-1:0] clamp_last(input logic [DIM_W-1:0] dim,
                                                   input int max_dim);
      logic [DIM_W-1:0] lim;
      lim = DIM_W'(max_dim);
      if (dim == '0) begin
         return '0;
      end else if (dim > lim) begin
         return IDX_W'(lim - 1'b1);
      end else begin
         return IDX_W'(dim - 1'b1);
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/imm_if.sv =====
`default_nettype none

// request channel: element writes and compute commands
interface imm_req_if import imm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic [IDX_W-1:0]         row_index;
   logic [IDX_W-1:0]         col_index;
   logic signed [DATA_W-1:0] element_value;

   modport source (output valid, func, row_index, col_index, element_value, input ready);
   modport sink   (input valid, func, row_index, col_index, element_value, output ready);
endinterface

// response channel: product elements in row-major order
interface imm_rsp_if import imm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         out_row;
   logic [IDX_W-1:0]         out_col;
   logic signed [DATA_W-1:0] product_value;
   logic                     last;

   modport source (output valid, out_row, out_col, product_value, last, input ready);
   modport sink   (input valid, out_row, out_col, product_value, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/imm_ram.sv =====
`default_nettype none

module imm_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              write_enable,
   input  wire logic [ADDR_W-1:0] write_address,
   input  wire logic [WIDTH-1:0]  write_data,
   input  wire logic [ADDR_W-1:0] read_address,
   output logic      [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

// ===== rtl/integer_matrix_multiply.sv =====
`default_nettype none

// Signed 32-bit matrix product C = A x B, with A of rows_a by inner_dim and B of
// inner_dim by cols_b, each dimension 1 to MAX_DIM (0 acts as 1, larger values
// saturate). A and B live in two single-port-write RAMs with a registered read.
// Write items (func 0 for A, 1 for B) are taken only while idle; a write whose
// row or column is not below MAX_DIM is dropped. A compute item (func 2) emits
// every element of C in row-major order, the final one flagged with last; sums
// wrap modulo 2^32. Each inner-product term is a RAM read pair, then passes
// through the multiplier and the accumulator; each finished element waits in
// the output register until accepted. No new item is taken until the last
// element has been accepted, so reads of the stores never meet a write. Entries
// must be written before a compute reads them.
module integer_matrix_multiply import imm_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   imm_req_if.sink                     req_port,
   imm_rsp_if.source                   rsp_port,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]       csr_write_data
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // configuration
   logic [DIM_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [IDX_W-1:0] nr_last, nk_last, nc_last;

   // sequencer
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic             req_take, rsp_take, issue, elem_last;

   // store access
   logic              wr_a, wr_b;
   logic              idx_ok;
   logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [DATA_W-1:0] rd_data_a, rd_data_b;

   // multiply-accumulate pipeline
   logic              rd_valid_ff, rd_first_ff, rd_last_ff;
   logic              mul_valid_ff, mul_first_ff, mul_last_ff;
   logic [DATA_W-1:0] prod_ff, acc_ff, acc_in;
   logic              result_load;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         out_row_ff, out_col_ff;
   logic signed [DATA_W-1:0] out_value_ff;
   logic                     out_last_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_W'(1);
         inner_dim_ff <= DIM_W'(1);
         cols_b_ff    <= DIM_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROWS_A:    rows_a_ff    <= csr_write_data;
            CSR_INNER_DIM: inner_dim_ff <= csr_write_data;
            CSR_COLS_B:    cols_b_ff    <= csr_write_data;
            default:       ;
         endcase
      end
   end

   assign nr_last = clamp_last(rows_a_ff, MAX_DIM);
   assign nk_last = clamp_last(inner_dim_ff, MAX_DIM);
   assign nc_last = clamp_last(cols_b_ff, MAX_DIM);

   // handshakes
   assign req_take  = req_port.valid && req_port.ready;
   assign rsp_take  = rsp_valid_ff && rsp_port.ready;
   assign elem_last = (i_ff == nr_last) && (j_ff == nc_last);

   // element write decode
   assign idx_ok  = (int'(req_port.row_index) < MAX_DIM) && (int'(req_port.col_index) < MAX_DIM);
   assign wr_addr = ADDR_W'(int'(req_port.row_index) * MAX_DIM + int'(req_port.col_index));

   always_comb begin
      wr_a = 1'b0;
      wr_b = 1'b0;
      unique case (req_port.func)
         FUNC_WRITE_A: wr_a = req_take && idx_ok;
         FUNC_WRITE_B: wr_b = req_take && idx_ok;
         default:      ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_port.func == FUNC_COMPUTE)) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (k_ff == nk_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (result_load) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_take) begin
               state_in = out_last_ff ? ST_IDLE : ST_ISSUE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_port.ready = 1'b0;
      issue          = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_port.ready = 1'b1;
         ST_ISSUE: issue          = 1'b1;
         default:  ;
      endcase
   end

   // loop counters: k per term, j and i per emitted element
   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      if (req_take) begin
         i_in = '0;
         j_in = '0;
         k_in = '0;
      end
      if (issue) begin
         k_in = (k_ff == nk_last) ? '0 : k_ff + 1'b1;
      end
      if (rsp_take && !out_last_ff) begin
         if (j_ff == nc_last) begin
            j_in = '0;
            i_in = i_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   // read addresses: A[i][k] and B[k][j]
   assign rd_addr_a = ADDR_W'(int'(i_ff) * MAX_DIM + int'(k_ff));
   assign rd_addr_b = ADDR_W'(int'(k_ff) * MAX_DIM + int'(j_ff));

   imm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store_a (
      .clock         (clock),
      .write_enable  (wr_a),
      .write_address (wr_addr),
      .write_data    (req_port.element_value),
      .read_address  (rd_addr_a),
      .read_data     (rd_data_a)
   );

   imm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store_b (
      .clock         (clock),
      .write_enable  (wr_b),
      .write_address (wr_addr),
      .write_data    (req_port.element_value),
      .read_address  (rd_addr_b),
      .read_data     (rd_data_b)
   );

   // pipeline control tags follow the reads
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= issue;
         mul_valid_ff <= rd_valid_ff;
      end
   end

   // multiply stage, low half of the product kept
   always_ff @(posedge clock) begin
      rd_first_ff  <= (k_ff == '0);
      rd_last_ff   <= (k_ff == nk_last);
      mul_first_ff <= rd_first_ff;
      mul_last_ff  <= rd_last_ff;
      prod_ff      <= rd_data_a * rd_data_b;
   end

   // accumulate stage, restarted on the first term of an element
   assign acc_in      = (mul_first_ff ? '0 : acc_ff) + prod_ff;
   assign result_load = mul_valid_ff && mul_last_ff;

   always_ff @(posedge clock) begin
      if (mul_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         out_row_ff   <= i_ff;
         out_col_ff   <= j_ff;
         out_value_ff <= $signed(acc_in);
         out_last_ff  <= elem_last;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.out_row       = out_row_ff;
   assign rsp_port.out_col       = out_col_ff;
   assign rsp_port.product_value = out_value_ff;
   assign rsp_port.last          = out_last_ff;

   // a result is only shown while the sequencer waits on it
   a_rsp_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_EMIT))
      else $error("response valid outside emit");

   // the output register is empty whenever a sum completes
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result_load |-> !rsp_valid_ff)
      else $error("result overwrites pending item");

   // no item is taken while the multiply-accumulate pipe holds work
   a_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      req_port.ready |-> (!rd_valid_ff && !mul_valid_ff))
      else $error("item accepted with pipeline busy");

   // a compute item starts issuing reads on the next cycle
   a_compute_start: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_port.func == FUNC_COMPUTE)) |=> (state_ff == ST_ISSUE))
      else $error("compute did not start");

   // a sum completes only in the flush state
   a_load_in_flush: assert property (@(posedge clock) disable iff (reset)
      result_load |-> (state_ff == ST_FLUSH))
      else $error("sum completed outside flush");

endmodule

`default_nettype wire
